// ===== hw/rtl/iapb_pkg.sv =====
// shared types and constants of the ankle balance controller
package iapb_pkg;

  // field and register widths
  localparam int ANGLE_W   = 16;
  localparam int KEEP_W    = 17;
  localparam int MAXC_W    = 15;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int FILT_W    = 24;
  localparam int MUL_A_W   = 18;
  localparam int MUL_B_W   = FILT_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int CORR_W    = ACC_W - 16;
  localparam int FRAC_SHIFT = 16;

  // unity keep ratio and rounding constants
  localparam logic [KEEP_W-1:0]        ONE_Q16   = 17'd65536;
  localparam logic signed [PROD_W-1:0] PROD_HALF = 43'sd32768;
  localparam logic signed [ACC_W-1:0]  ACC_HALF  = 44'sd32768;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_RATIO       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_ANGLE_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_RATE_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_ANGLE_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_RATE_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CORRECTION   = 3'd5;

  // gain pair of one axis lane
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_gain;
    logic signed [ANGLE_W-1:0] rate_gain;
  } lane_gain_t;

  // lane sequencer steps
  typedef enum logic [2:0] {
    L_IDLE,
    L_FILT_ANGLE,
    L_FILT_RATE,
    L_MUL_P,
    L_MUL_D,
    L_SUM,
    L_CLAMP,
    L_DONE
  } lane_step_t;

  // top level control states
  typedef enum logic [1:0] {
    T_IDLE,
    T_RUN,
    T_WAIT
  } top_state_t;

endpackage

// ===== hw/rtl/iapb_lane.sv =====
// one axis lane: angle and rate low-pass filters and saturated pd correction
module iapb_lane import iapb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      kind,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic signed [ANGLE_W-1:0] rate,
  input  logic [KEEP_W-1:0]         keep,
  input  lane_gain_t                gain,
  input  logic [MAXC_W-1:0]         max_corr,
  output logic                      done,
  output logic signed [ANGLE_W-1:0] corr
);

  lane_step_t step, step_next;

  logic signed [FILT_W-1:0]  filt_angle;
  logic signed [FILT_W-1:0]  filt_rate;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic [KEEP_W-1:0]         k_eff;
  logic signed [FILT_W-1:0]  x_angle;
  logic signed [FILT_W-1:0]  x_rate;
  logic signed [FILT_W-1:0]  x_sel;
  logic signed [MUL_B_W-1:0] diff_angle;
  logic signed [MUL_B_W-1:0] diff_rate;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_out;
  logic signed [PROD_W-1:0]  prod_round;
  logic signed [FILT_W:0]    filt_upd;
  logic signed [ACC_W-1:0]   prod_x4;
  logic signed [ACC_W-1:0]   acc_round;
  logic signed [CORR_W-1:0]  corr_raw;
  logic signed [CORR_W-1:0]  lim_pos;
  logic signed [CORR_W-1:0]  lim_neg;
  logic signed [CORR_W-1:0]  corr_clamp;

  // keep ratio above one holds the filter
  assign k_eff = (keep > ONE_Q16) ? ONE_Q16 : keep;

  // samples scaled up to the filter format
  assign x_angle = {angle, 8'b0};
  assign x_rate  = {rate, 8'b0};
  assign diff_angle = {filt_angle[FILT_W-1], filt_angle} - {x_angle[FILT_W-1], x_angle};
  assign diff_rate  = {filt_rate[FILT_W-1], filt_rate} - {x_rate[FILT_W-1], x_rate};

  // operand selection for the shared multiplier
  always_comb begin
    unique case (step)
      L_FILT_ANGLE: begin
        mul_a = $signed({1'b0, k_eff});
        mul_b = diff_angle;
      end
      L_FILT_RATE: begin
        mul_a = $signed({1'b0, k_eff});
        mul_b = diff_rate;
      end
      L_MUL_P: begin
        mul_a = {{(MUL_A_W-ANGLE_W){gain.angle_gain[ANGLE_W-1]}}, gain.angle_gain};
        mul_b = {filt_angle[FILT_W-1], filt_angle};
      end
      L_MUL_D: begin
        mul_a = {{(MUL_A_W-ANGLE_W){gain.rate_gain[ANGLE_W-1]}}, gain.rate_gain};
        mul_b = {filt_rate[FILT_W-1], filt_rate};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  // filter update: sample plus rounded weighted difference
  assign x_sel      = (step == L_MUL_P) ? x_rate : x_angle;
  assign prod_round = (prod + PROD_HALF) >>> FRAC_SHIFT;
  assign filt_upd   = {x_sel[FILT_W-1], x_sel} + prod_round[FILT_W:0];

  // pd sum rounding and limit
  assign prod_x4   = {prod[PROD_W-2:0], 2'b00};
  assign acc_round = (acc + ACC_HALF) >>> FRAC_SHIFT;
  assign corr_raw  = acc_round[CORR_W-1:0];
  assign lim_pos   = $signed({{(CORR_W-MAXC_W){1'b0}}, max_corr});
  assign lim_neg   = -lim_pos;

  always_comb begin
    priority if (corr_raw > lim_pos) begin
      corr_clamp = lim_pos;
    end else if (corr_raw < lim_neg) begin
      corr_clamp = lim_neg;
    end else begin
      corr_clamp = corr_raw;
    end
  end

  // step register
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= L_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // step sequence
  always_comb begin
    unique case (step)
      L_IDLE:       step_next = start ? L_FILT_ANGLE : L_IDLE;
      L_FILT_ANGLE: step_next = L_FILT_RATE;
      L_FILT_RATE:  step_next = L_MUL_P;
      L_MUL_P:      step_next = L_MUL_D;
      L_MUL_D:      step_next = L_SUM;
      L_SUM:        step_next = L_CLAMP;
      L_CLAMP:      step_next = L_DONE;
      L_DONE:       step_next = L_IDLE;
      default:      step_next = L_IDLE;
    endcase
  end

  assign done = (step == L_DONE);

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      filt_angle <= '0;
      filt_rate  <= '0;
    end else begin
      if (step == L_FILT_RATE) begin
        filt_angle <= kind ? x_angle : filt_upd[FILT_W-1:0];
      end
      if (step == L_MUL_P) begin
        filt_rate <= kind ? x_rate : filt_upd[FILT_W-1:0];
      end
    end
  end

  // product, accumulator and correction
  always_ff @(posedge clk) begin
    prod <= mul_out;
    if (step == L_MUL_D) begin
      acc <= {prod[PROD_W-1], prod};
    end
    if (step == L_SUM) begin
      acc <= acc + prod_x4;
    end
    if (step == L_CLAMP) begin
      corr <= kind ? '0 : corr_clamp[ANGLE_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/iapb_merge.sv =====
// merging stage: ankle sums with saturation and the output register
module iapb_merge import iapb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic                      out_stall,
  input  logic signed [ANGLE_W-1:0] pitch_corr,
  input  logic signed [ANGLE_W-1:0] roll_corr,
  input  logic signed [ANGLE_W-1:0] left_pitch_cmd,
  input  logic signed [ANGLE_W-1:0] right_pitch_cmd,
  input  logic signed [ANGLE_W-1:0] left_roll_cmd,
  input  logic signed [ANGLE_W-1:0] right_roll_cmd,
  output logic                      free,
  output logic                      out_valid,
  output logic signed [ANGLE_W-1:0] pitch_correction,
  output logic signed [ANGLE_W-1:0] roll_correction,
  output logic signed [ANGLE_W-1:0] left_pitch_out,
  output logic signed [ANGLE_W-1:0] right_pitch_out,
  output logic signed [ANGLE_W-1:0] left_roll_out,
  output logic signed [ANGLE_W-1:0] right_roll_out
);

  localparam logic signed [ANGLE_W:0] SUM_MAX = 17'sd32767;
  localparam logic signed [ANGLE_W:0] SUM_MIN = -17'sd32768;

  // saturating add into the angle range
  function automatic logic signed [ANGLE_W-1:0] sat_add(
    input logic signed [ANGLE_W-1:0] a,
    input logic signed [ANGLE_W-1:0] b
  );
    logic signed [ANGLE_W:0] s;
    s = {a[ANGLE_W-1], a} + {b[ANGLE_W-1], b};
    if (s > SUM_MAX) begin
      return SUM_MAX[ANGLE_W-1:0];
    end else if (s < SUM_MIN) begin
      return SUM_MIN[ANGLE_W-1:0];
    end
    return s[ANGLE_W-1:0];
  endfunction

  assign free = !out_valid || !out_stall;

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      pitch_correction <= pitch_corr;
      roll_correction  <= roll_corr;
      left_pitch_out   <= sat_add(left_pitch_cmd, pitch_corr);
      right_pitch_out  <= sat_add(right_pitch_cmd, pitch_corr);
      left_roll_out    <= sat_add(left_roll_cmd, roll_corr);
      right_roll_out   <= sat_add(right_roll_cmd, roll_corr);
    end
  end

endmodule

// ===== hw/rtl/imu_ankle_pd_balance_unit.sv =====
// top level of the imu ankle balance controller: config, lanes and merge
//
//   channel  handshake             payload
//   in       in_valid / in_stall   kind, torso angles, gyro rates, ankle commands
//   out      out_valid / out_stall corrections and corrected ankle angles
//   cfg      cfg_write_en          cfg_index, cfg_data
//
// a result passes seven lane steps in the pitch and roll lanes (one shared
// multiplier per lane, four products each) and then the wait state, which
// hands it to the output register once that register is free.
// rst is synchronous; it clears filters, config registers, states and out_valid.
// a new request is taken once the previous one has been loaded into the
// output register, even while that result still waits there under out_stall.
module imu_ankle_pd_balance_unit import iapb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic signed [ANGLE_W-1:0] torso_roll,
  input  logic signed [ANGLE_W-1:0] torso_pitch,
  input  logic signed [ANGLE_W-1:0] rate_roll,
  input  logic signed [ANGLE_W-1:0] rate_pitch,
  input  logic signed [ANGLE_W-1:0] left_pitch_in,
  input  logic signed [ANGLE_W-1:0] right_pitch_in,
  input  logic signed [ANGLE_W-1:0] left_roll_in,
  input  logic signed [ANGLE_W-1:0] right_roll_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [ANGLE_W-1:0] pitch_correction,
  output logic signed [ANGLE_W-1:0] roll_correction,
  output logic signed [ANGLE_W-1:0] left_pitch_out,
  output logic signed [ANGLE_W-1:0] right_pitch_out,
  output logic signed [ANGLE_W-1:0] left_roll_out,
  output logic signed [ANGLE_W-1:0] right_roll_out
);

  top_state_t state, state_next;

  logic [KEEP_W-1:0] keep_ratio;
  lane_gain_t        pitch_gain;
  lane_gain_t        roll_gain;
  logic [MAXC_W-1:0] max_correction;

  logic                      req_kind;
  logic signed [ANGLE_W-1:0] req_roll;
  logic signed [ANGLE_W-1:0] req_pitch;
  logic signed [ANGLE_W-1:0] req_rate_roll;
  logic signed [ANGLE_W-1:0] req_rate_pitch;
  logic signed [ANGLE_W-1:0] req_left_pitch;
  logic signed [ANGLE_W-1:0] req_right_pitch;
  logic signed [ANGLE_W-1:0] req_left_roll;
  logic signed [ANGLE_W-1:0] req_right_roll;

  logic                      accept;
  logic                      pitch_done;
  logic                      roll_done;
  logic signed [ANGLE_W-1:0] pitch_corr;
  logic signed [ANGLE_W-1:0] roll_corr;
  logic                      out_free;
  logic                      load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_ratio     <= '0;
      pitch_gain     <= '0;
      roll_gain      <= '0;
      max_correction <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_KEEP_RATIO:       keep_ratio            <= cfg_data;
        REG_PITCH_ANGLE_GAIN: pitch_gain.angle_gain <= cfg_data[ANGLE_W-1:0];
        REG_PITCH_RATE_GAIN:  pitch_gain.rate_gain  <= cfg_data[ANGLE_W-1:0];
        REG_ROLL_ANGLE_GAIN:  roll_gain.angle_gain  <= cfg_data[ANGLE_W-1:0];
        REG_ROLL_RATE_GAIN:   roll_gain.rate_gain   <= cfg_data[ANGLE_W-1:0];
        REG_MAX_CORRECTION:   max_correction        <= cfg_data[MAXC_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != T_IDLE);
  assign accept   = in_valid && !in_stall;

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind        <= kind;
      req_roll        <= torso_roll;
      req_pitch       <= torso_pitch;
      req_rate_roll   <= rate_roll;
      req_rate_pitch  <= rate_pitch;
      req_left_pitch  <= left_pitch_in;
      req_right_pitch <= right_pitch_in;
      req_left_roll   <= left_roll_in;
      req_right_roll  <= right_roll_in;
    end
  end

  // control state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and result hand-over
  always_comb begin
    state_next = state;
    load       = 1'b0;
    unique case (state)
      T_IDLE: begin
        if (accept) state_next = T_RUN;
      end
      T_RUN: begin
        if (pitch_done && roll_done) state_next = T_WAIT;
      end
      T_WAIT: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  // pitch axis lane
  iapb_lane u_pitch_lane (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .kind     (req_kind),
    .angle    (req_pitch),
    .rate     (req_rate_pitch),
    .keep     (keep_ratio),
    .gain     (pitch_gain),
    .max_corr (max_correction),
    .done     (pitch_done),
    .corr     (pitch_corr)
  );

  // roll axis lane
  iapb_lane u_roll_lane (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .kind     (req_kind),
    .angle    (req_roll),
    .rate     (req_rate_roll),
    .keep     (keep_ratio),
    .gain     (roll_gain),
    .max_corr (max_correction),
    .done     (roll_done),
    .corr     (roll_corr)
  );

  // merge corrections into the ankle commands
  iapb_merge u_merge (
    .clk              (clk),
    .rst              (rst),
    .load             (load),
    .out_stall        (out_stall),
    .pitch_corr       (pitch_corr),
    .roll_corr        (roll_corr),
    .left_pitch_cmd   (req_left_pitch),
    .right_pitch_cmd  (req_right_pitch),
    .left_roll_cmd    (req_left_roll),
    .right_roll_cmd   (req_right_roll),
    .free             (out_free),
    .out_valid        (out_valid),
    .pitch_correction (pitch_correction),
    .roll_correction  (roll_correction),
    .left_pitch_out   (left_pitch_out),
    .right_pitch_out  (right_pitch_out),
    .left_roll_out    (left_roll_out),
    .right_roll_out   (right_roll_out)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the imu ankle pd balance unit
module tb;
  import iapb_pkg::*;

  // request kinds and the unused register slots
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_RESYNC = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // arithmetic constants
  localparam int     ANGLE_HI   = 32767;
  localparam int     ANGLE_LO   = -32768;
  localparam longint UNITY      = 65536;
  localparam longint ROUND_HALF = 32768;
  localparam int     SETTLE_CYCLES = 30;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [FILT_W-1:0]  filt_t;

  localparam angle_t A_MAX = 16'h7fff;
  localparam angle_t A_MIN = 16'h8000;

  // one control frame and the ankle command it produces
  typedef struct packed {
    logic   kind;
    angle_t roll, pitch, roll_rate, pitch_rate;
    angle_t left_pitch, right_pitch, left_roll, right_roll;
  } frame_t;

  typedef struct packed {
    angle_t pitch_corr, roll_corr;
    angle_t left_pitch, right_pitch, left_roll, right_roll;
  } ankle_cmd_t;

  // block ports
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 kind = 1'b0;
  angle_t torso_roll = '0, torso_pitch = '0, rate_roll = '0, rate_pitch = '0;
  angle_t left_pitch_in = '0, right_pitch_in = '0, left_roll_in = '0, right_roll_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  angle_t pitch_correction, roll_correction;
  angle_t left_pitch_out, right_pitch_out, left_roll_out, right_roll_out;

  // predictor copy of the registers and the filter state
  logic [KEEP_W-1:0] keep_ratio_m = '0;
  angle_t            pitch_kp = '0, pitch_kd = '0, roll_kp = '0, roll_kd = '0;
  logic [MAXC_W-1:0] corr_limit = '0;
  filt_t filt_roll = '0, filt_pitch = '0, filt_roll_rate = '0, filt_pitch_rate = '0;

  ankle_cmd_t pending_cmds[$];
  int error_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;

  imu_ankle_pd_balance_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .torso_roll(torso_roll), .torso_pitch(torso_pitch),
    .rate_roll(rate_roll), .rate_pitch(rate_pitch),
    .left_pitch_in(left_pitch_in), .right_pitch_in(right_pitch_in),
    .left_roll_in(left_roll_in), .right_roll_in(right_roll_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .pitch_correction(pitch_correction), .roll_correction(roll_correction),
    .left_pitch_out(left_pitch_out), .right_pitch_out(right_pitch_out),
    .left_roll_out(left_roll_out), .right_roll_out(right_roll_out)
  );

  always #6 clk = ~clk;

  // first-order low-pass on the q.21 / q.19 held value
  function automatic filt_t lowpass_step(filt_t old_val, angle_t meas);
    longint k;
    longint acc;
    k = (keep_ratio_m > ONE_Q16) ? UNITY : longint'(keep_ratio_m);
    acc = k * longint'(old_val) + (UNITY - k) * (longint'(meas) * 256) + ROUND_HALF;
    return filt_t'(acc >>> FRAC_SHIFT);
  endfunction

  // pd sum, rounded back to q2.13 and limited to the correction range
  function automatic angle_t pd_term(angle_t kp, filt_t fa, angle_t kd, filt_t fr);
    longint s;
    longint c;
    longint lim;
    lim = longint'(corr_limit);
    s = longint'(kp) * longint'(fa) + longint'(kd) * longint'(fr) * 4;
    c = (s + ROUND_HALF) >>> FRAC_SHIFT;
    if (c > lim) c = lim;
    if (c < -lim) c = -lim;
    return angle_t'(c);
  endfunction

  function automatic angle_t add_sat(angle_t cmd, angle_t corr);
    int sum;
    sum = int'(cmd) + int'(corr);
    if (sum > ANGLE_HI) sum = ANGLE_HI;
    if (sum < ANGLE_LO) sum = ANGLE_LO;
    return angle_t'(sum);
  endfunction

  // advance the filter state by one frame and form the ankle command
  function automatic ankle_cmd_t predict_ankles(frame_t f);
    ankle_cmd_t r;
    r.pitch_corr = '0;
    r.roll_corr  = '0;
    if (f.kind == KIND_RESYNC) begin
      filt_roll       = filt_t'(longint'(f.roll) * 256);
      filt_pitch      = filt_t'(longint'(f.pitch) * 256);
      filt_roll_rate  = filt_t'(longint'(f.roll_rate) * 256);
      filt_pitch_rate = filt_t'(longint'(f.pitch_rate) * 256);
    end else begin
      filt_roll       = lowpass_step(filt_roll, f.roll);
      filt_pitch      = lowpass_step(filt_pitch, f.pitch);
      filt_roll_rate  = lowpass_step(filt_roll_rate, f.roll_rate);
      filt_pitch_rate = lowpass_step(filt_pitch_rate, f.pitch_rate);
      r.pitch_corr = pd_term(pitch_kp, filt_pitch, pitch_kd, filt_pitch_rate);
      r.roll_corr  = pd_term(roll_kp, filt_roll, roll_kd, filt_roll_rate);
    end
    r.left_pitch  = add_sat(f.left_pitch, r.pitch_corr);
    r.right_pitch = add_sat(f.right_pitch, r.pitch_corr);
    r.left_roll   = add_sat(f.left_roll, r.roll_corr);
    r.right_roll  = add_sat(f.right_roll, r.roll_corr);
    return r;
  endfunction

  // random field values, weighted towards the range ends and small angles
  function automatic angle_t pick_angle();
    case ($urandom_range(7))
      0: return A_MAX;
      1: return A_MIN;
      2: return angle_t'(int'($urandom_range(512)) - 256);
      default: return angle_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain();
    logic [CFG_W-1:0] g;
    case ($urandom_range(9))
      0: g = {1'b0, A_MAX};
      1: g = {1'b0, A_MIN};
      2: g = '0;
      3, 4, 5, 6: g = {1'b0, angle_t'(int'($urandom_range(2048)) - 1024)};
      default: g = CFG_W'($urandom);
    endcase
    g[CFG_W-1] = 1'($urandom);
    return g;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    f.kind        = ($urandom_range(9) == 0) ? KIND_RESYNC : KIND_UPDATE;
    f.roll        = pick_angle();
    f.pitch       = pick_angle();
    f.roll_rate   = pick_angle();
    f.pitch_rate  = pick_angle();
    f.left_pitch  = pick_angle();
    f.right_pitch = pick_angle();
    f.left_roll   = pick_angle();
    f.right_roll  = pick_angle();
    return f;
  endfunction

  // mismatch reporting
  task automatic report_mismatch(string what);
    error_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, angle_t got, angle_t want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // register write, mirrored into the predictor
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    case (idx)
      REG_KEEP_RATIO:       keep_ratio_m = value[KEEP_W-1:0];
      REG_PITCH_ANGLE_GAIN: pitch_kp = value[ANGLE_W-1:0];
      REG_PITCH_RATE_GAIN:  pitch_kd = value[ANGLE_W-1:0];
      REG_ROLL_ANGLE_GAIN:  roll_kp = value[ANGLE_W-1:0];
      REG_ROLL_RATE_GAIN:   roll_kd = value[ANGLE_W-1:0];
      REG_MAX_CORRECTION:   corr_limit = value[MAXC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] keep, logic [CFG_W-1:0] pkp,
                           logic [CFG_W-1:0] pkd, logic [CFG_W-1:0] rkp,
                           logic [CFG_W-1:0] rkd, logic [CFG_W-1:0] maxc);
    write_reg(REG_KEEP_RATIO, keep);
    write_reg(REG_PITCH_ANGLE_GAIN, pkp);
    write_reg(REG_PITCH_RATE_GAIN, pkd);
    write_reg(REG_ROLL_ANGLE_GAIN, rkp);
    write_reg(REG_ROLL_RATE_GAIN, rkd);
    write_reg(REG_MAX_CORRECTION, maxc);
  endtask

  task automatic random_settings();
    logic [CFG_W-1:0] keep;
    logic [CFG_W-1:0] maxc;
    case ($urandom_range(5))
      0: keep = '0;
      1: keep = ONE_Q16;
      2: keep = CFG_W'($urandom_range(131071, 65537));
      default: keep = CFG_W'($urandom_range(65535));
    endcase
    case ($urandom_range(5))
      0: maxc = '0;
      1: maxc = 17'd32767;
      default: maxc = CFG_W'($urandom_range(32767));
    endcase
    configure(keep, pick_gain(), pick_gain(), pick_gain(), pick_gain(), maxc);
  endtask

  // send one request; called and returning at a falling edge
  task automatic send_frame(frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= f.kind;
    torso_roll     <= f.roll;
    torso_pitch    <= f.pitch;
    rate_roll      <= f.roll_rate;
    rate_pitch     <= f.pitch_rate;
    left_pitch_in  <= f.left_pitch;
    right_pitch_in <= f.right_pitch;
    left_roll_in   <= f.left_roll;
    right_roll_in  <= f.right_roll;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_cmds.push_back(predict_ankles(f));
    @(negedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_cmds.size() != 0) @(negedge clk);
  endtask

  // receiver side: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    ankle_cmd_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_cmds.pop_front();
        check_field("pitch_correction", pitch_correction, want.pitch_corr);
        check_field("roll_correction", roll_correction, want.roll_corr);
        check_field("left_pitch_out", left_pitch_out, want.left_pitch);
        check_field("right_pitch_out", right_pitch_out, want.right_pitch);
        check_field("left_roll_out", left_roll_out, want.left_roll);
        check_field("right_roll_out", right_roll_out, want.right_roll);
      end
    end
  end

  // registers at reset value: gains and limit zero, ankles pass through
  task automatic test_power_on_defaults();
    send_frame(frame_t'{KIND_UPDATE, A_MAX, A_MIN, A_MAX, A_MIN,
                        A_MAX, A_MIN, 16'h0001, 16'hffff});
    send_frame(frame_t'{KIND_RESYNC, A_MIN, A_MAX, A_MIN, A_MAX,
                        A_MIN, A_MAX, 16'hffff, 16'h0001});
    wait_idle();
  endtask

  // field extremes, correction clamp and ankle saturation both ways
  task automatic test_field_extremes();
    configure(17'd0, 17'd256, 17'd0, 17'd0, 17'd256, 17'd32767);
    send_frame(frame_t'{KIND_UPDATE, 16'h0, A_MAX, 16'h0, 16'h0,
                        A_MAX, A_MAX, 16'h0, 16'h0});
    send_frame(frame_t'{KIND_UPDATE, 16'h0, A_MIN, 16'h0, 16'h0,
                        A_MIN, A_MIN, 16'h0, 16'h0});
    send_frame(frame_t'{KIND_UPDATE, 16'h0, 16'h0, 16'h2000, 16'h0,
                        16'h0, 16'h0, A_MAX, A_MIN});
    send_frame(frame_t'{KIND_UPDATE, 16'h0, 16'h0, A_MIN, 16'h0,
                        16'h0, 16'h0, A_MIN, A_MAX});
    wait_idle();
    configure(17'd0, 17'h08000, 17'h07fff, 17'h07fff, 17'h08000, 17'h07fff);
    send_frame(frame_t'{KIND_UPDATE, A_MAX, A_MAX, A_MAX, A_MAX,
                        A_MAX, A_MAX, A_MAX, A_MAX});
    send_frame(frame_t'{KIND_UPDATE, A_MIN, A_MIN, A_MIN, A_MIN,
                        A_MIN, A_MIN, A_MIN, A_MIN});
    send_frame(frame_t'{KIND_UPDATE, A_MAX, A_MIN, A_MIN, A_MAX,
                        16'h0001, 16'hffff, 16'h0, 16'h0});
    wait_idle();
  endtask

  // a zero limit forces both corrections to zero
  task automatic test_zero_limit();
    configure(17'd0, 17'd256, 17'd256, 17'd256, 17'd256, 17'd0);
    send_frame(frame_t'{KIND_UPDATE, A_MAX, A_MAX, A_MAX, A_MAX,
                        A_MAX, A_MIN, A_MAX, A_MIN});
    send_frame(random_frame());
    wait_idle();
  endtask

  // keep ratio at and above one holds the filters
  task automatic test_keep_above_one();
    configure(17'd0, 17'd256, 17'd0, 17'd256, 17'd0, 17'd32767);
    send_frame(frame_t'{KIND_UPDATE, -16'sd1000, 16'sd1000, 16'h0, 16'h0,
                        16'h0, 16'h0, 16'h0, 16'h0});
    wait_idle();
    write_reg(REG_KEEP_RATIO, 17'h1ffff);
    send_frame(frame_t'{KIND_UPDATE, 16'sd5000, -16'sd5000, A_MAX, A_MIN,
                        16'sd100, -16'sd100, 16'sd200, -16'sd200});
    wait_idle();
    write_reg(REG_KEEP_RATIO, ONE_Q16);
    send_frame(random_frame());
    wait_idle();
    write_reg(REG_KEEP_RATIO, 17'd32768);
    send_frame(random_frame());
    wait_idle();
  endtask

  // a resync request reloads the filters and gives zero corrections
  task automatic test_resync_item();
    configure(17'd49152, 17'd512, 17'h0ff00, 17'd300, 17'd64, 17'd20000);
    send_frame(random_frame());
    send_frame(random_frame());
    send_frame(frame_t'{KIND_RESYNC, A_MAX, A_MIN, A_MIN, A_MAX,
                        A_MAX, A_MIN, 16'h1234, -16'sd77});
    send_frame(frame_t'{KIND_UPDATE, 16'h0, 16'h0, 16'h0, 16'h0,
                        16'h0, 16'h0, 16'h0, 16'h0});
    send_frame(random_frame());
    wait_idle();
  endtask

  // writes to unused indexes leave the settings alone
  task automatic test_spare_registers();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    send_frame(random_frame());
    send_frame(random_frame());
    wait_idle();
  endtask

  // random frames under a fresh random setting per phase
  task automatic test_random_traffic(int phases, int per_phase);
    repeat (phases) begin
      random_settings();
      repeat (per_phase) send_frame(random_frame());
      wait_idle();
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    random_settings();
    @(posedge clk);
    hold_left = 200;
    @(negedge clk);
    repeat (30) send_frame(random_frame());
    wait_idle();
  endtask

  // main sequence
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 16;
    recv_idle_pct = 66;
    test_power_on_defaults();
    test_field_extremes();
    test_zero_limit();
    test_keep_above_one();
    test_resync_item();
    test_spare_registers();
    test_random_traffic(2, 100);

    send_idle_pct = 66;
    recv_idle_pct = 16;
    test_random_traffic(2, 100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(3, 100);
    test_backpressure();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
